/* rtl/core/omni_wheel_mixer_macros.svh */
// Assertion macros for the omni wheel mixer.
`ifndef OMNI_WHEEL_MIXER_MACROS_SVH
`define OMNI_WHEEL_MIXER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OWM_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("omni_wheel_mixer: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OWM_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("omni_wheel_mixer: assertion failed");

`endif

/* rtl/core/owm_pkg.sv */
// Types, widths and matrix coefficients of the omni wheel mixer.
package owm_pkg;

  localparam int FORCE_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int DUTY_W         = 8;
  localparam int WHEELS         = 3;

  // signed wheel value, its magnitude, and the divider numerator
  localparam int W_W   = FORCE_WIDTH + COEF_FRAC_BITS + 1;
  localparam int MAG_W = W_W - 1;
  localparam int NUM_W = MAG_W + DUTY_W;

  localparam logic [63:0] Q32_THIRD      = 64'd1431655765;
  localparam logic [63:0] Q32_TWO_THIRDS = 64'd2863311531;
  localparam logic [63:0] Q32_INV_SQRT3  = 64'd2479700525;

  localparam logic [DUTY_W-1:0] FULL_SCALE_RESET = 8'd180;

  // round half up from Q0.32 to COEF_FRAC_BITS fraction bits
  function automatic logic [COEF_FRAC_BITS-1:0] coef_round(input logic [63:0] q32);
    logic [63:0] r;
    r = (q32 + (64'd1 << (31 - COEF_FRAC_BITS))) >> (32 - COEF_FRAC_BITS);
    return r[COEF_FRAC_BITS-1:0];
  endfunction

  localparam logic [COEF_FRAC_BITS-1:0] COEF_THIRD      = coef_round(Q32_THIRD);
  localparam logic [COEF_FRAC_BITS-1:0] COEF_TWO_THIRDS = coef_round(Q32_TWO_THIRDS);
  localparam logic [COEF_FRAC_BITS-1:0] COEF_INV_SQRT3  = coef_round(Q32_INV_SQRT3);

  typedef logic signed [FORCE_WIDTH-1:0] force_t;

  typedef struct packed {
    force_t force_x;
    force_t force_y;
    force_t force_turn;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_first;
    logic              forward_first;
    logic [DUTY_W-1:0] duty_second;
    logic              forward_second;
    logic [DUTY_W-1:0] duty_third;
    logic              forward_third;
  } out_t;

  // one divider stage: running remainders, partial quotients, divisor, directions
  typedef struct packed {
    logic [WHEELS-1:0][NUM_W-1:0]  rem;
    logic [WHEELS-1:0][DUTY_W-1:0] quo;
    logic [MAG_W-1:0]              m;
    logic [WHEELS-1:0]             pos;
  } div_t;

endpackage

/* rtl/core/omni_wheel_mixer.sv */
// Omni wheel mixer: three-wheel inverse kinematics with duty normalization.
// One force command (x, y, turn) is taken per cycle while stall_o is low, and
// yields three wheel duties and direction bits. Stages 1-4 form the matrix
// products, the wheel sums, the magnitudes, and the largest magnitude with each
// magnitude times pwm_full_scale; stages 5-12 are a restoring divider that settles
// one quotient bit per stage, so the divider depth follows the 8-bit duty width.
// A command whose three wheel values are all zero is dropped at stage 4 and gives
// no transaction. Each stage holds its item while the next is full and stalled, so
// bubbles close up and the input keeps flowing while a result waits at the output
// until every stage is full. pwm_full_scale resets to 180; the user writes it via
// cfg_we_i / cfg_wdata_i only while the pipeline is empty, which is not enforced.
module omni_wheel_mixer
  import owm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DUTY_W-1:0] cfg_wdata_i,
  input  logic              valid_i,
  output logic              stall_o,
  input  in_t               data_i,
  output logic              valid_o,
  input  logic              stall_i,
  output out_t              data_o
);

  logic [DUTY_W-1:0] fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FULL_SCALE_RESET;
    end else if (cfg_we_i) begin
      fs_q <= cfg_wdata_i;
    end
  end

  // ---------------- handshake chain ----------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic dv_q   [DUTY_W+1];
  logic en_div [DUTY_W+1];
  div_t div_q  [DUTY_W+1];

  assign en_div[DUTY_W] = !dv_q[DUTY_W] || !stall_i;
  assign en3     = !v3_q || en_div[0];
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  // ---------------- stage 1: products ----------------
  logic signed [W_W-1:0] fx, fy, ft;
  logic signed [W_W-1:0] c_third, c_two, c_inv;
  logic signed [W_W-1:0] p_tx_q, p_iy_q, p_tt_q, p_2x_q;

  assign fx      = W_W'(data_i.force_x);
  assign fy      = W_W'(data_i.force_y);
  assign ft      = W_W'(data_i.force_turn);
  assign c_third = W_W'($signed({1'b0, COEF_THIRD}));
  assign c_two   = W_W'($signed({1'b0, COEF_TWO_THIRDS}));
  assign c_inv   = W_W'($signed({1'b0, COEF_INV_SQRT3}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      p_tx_q <= c_third * fx;
      p_iy_q <= c_inv * fy;
      p_tt_q <= c_third * ft;
      p_2x_q <= c_two * fx;
    end
  end

  // ---------------- stage 2: wheel sums ----------------
  logic signed [W_W-1:0] w_q [WHEELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      w_q[0] <= p_tx_q - p_iy_q + p_tt_q;
      w_q[1] <= p_tt_q - p_2x_q;
      w_q[2] <= p_tx_q + p_iy_q + p_tt_q;
    end
  end

  // ---------------- stage 3: magnitudes ----------------
  logic [MAG_W-1:0]  mag_q [WHEELS];
  logic [WHEELS-1:0] pos_q;
  logic [W_W-1:0]    neg_w [WHEELS];

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      neg_w[i] = -w_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      for (int i = 0; i < WHEELS; i++) begin
        mag_q[i] <= w_q[i][W_W-1] ? neg_w[i][MAG_W-1:0] : w_q[i][MAG_W-1:0];
        pos_q[i] <= !w_q[i][W_W-1] && (w_q[i] != '0);
      end
    end
  end

  // ---------------- stage 4: max and numerators ----------------
  logic [MAG_W-1:0] m01, m_max;
  div_t             div0_d;

  always_comb begin
    m01   = (mag_q[1] > mag_q[0]) ? mag_q[1] : mag_q[0];
    m_max = (mag_q[2] > m01) ? mag_q[2] : m01;
    div0_d.m   = m_max;
    div0_d.pos = pos_q;
    for (int i = 0; i < WHEELS; i++) begin
      div0_d.rem[i] = NUM_W'(mag_q[i]) * NUM_W'(fs_q);
      div0_d.quo[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_div[0]) begin
      // all-zero command yields no transaction
      dv_q[0] <= v3_q && (m_max != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_div[0] && v3_q) begin
      div_q[0] <= div0_d;
    end
  end

  // ---------------- stages 5-12: restoring divider ----------------
  for (genvar j = 1; j <= DUTY_W; j++) begin : g_div
    localparam int K = DUTY_W - j;
    div_t             step_d;
    logic [NUM_W-1:0] sub;

    // previous stage may load when it is empty or this stage loads
    assign en_div[j-1] = !dv_q[j-1] || en_div[j];

    always_comb begin
      step_d = div_q[j-1];
      sub    = NUM_W'(div_q[j-1].m) << K;
      for (int i = 0; i < WHEELS; i++) begin
        if (div_q[j-1].rem[i] >= sub) begin
          step_d.rem[i]    = div_q[j-1].rem[i] - sub;
          step_d.quo[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en_div[j]) begin
        dv_q[j] <= dv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_div[j] && dv_q[j-1]) begin
        div_q[j] <= step_d;
      end
    end
  end

  // ---------------- output ----------------
  assign valid_o               = dv_q[DUTY_W];
  assign data_o.duty_first     = div_q[DUTY_W].quo[0];
  assign data_o.forward_first  = div_q[DUTY_W].pos[0];
  assign data_o.duty_second    = div_q[DUTY_W].quo[1];
  assign data_o.forward_second = div_q[DUTY_W].pos[1];
  assign data_o.duty_third     = div_q[DUTY_W].quo[2];
  assign data_o.forward_third  = div_q[DUTY_W].pos[2];

  // ---------------- assertions ----------------
  logic rem_ok, peak_ok;

  assign rem_ok  = (div_q[DUTY_W].rem[0] < div_q[DUTY_W].m) &&
                   (div_q[DUTY_W].rem[1] < div_q[DUTY_W].m) &&
                   (div_q[DUTY_W].rem[2] < div_q[DUTY_W].m);
  assign peak_ok = (data_o.duty_first == fs_q) || (data_o.duty_second == fs_q) ||
                   (data_o.duty_third == fs_q);

`include "omni_wheel_mixer_macros.svh"

  `OWM_ASSERT_NXT(a_accept_fills, valid_i && !stall_o, v1_q)
  `OWM_ASSERT_IMP(a_rem_below_div, valid_o, rem_ok)
  `OWM_ASSERT_IMP(a_max_gets_full, valid_o, peak_ok)

endmodule
